[sv/gosc_pkg.sv]
package gosc_pkg;

    // Default segment buffer capacity in slots
    localparam int unsigned SEG_CAPACITY_DEFAULT = 2097152;

    // Fixed field widths
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SLOT_W  = 21;
    localparam int unsigned COUNT_W = 15;

    // Contour segment count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Result queue depth; two free entries are needed to take a vertex
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_QUAD  = 2'd2,
        KIND_CUBIC = 2'd3
    } kind_t;

    typedef enum logic {
        REC_SEGMENT = 1'b0,
        REC_PATCH   = 1'b1
    } rec_kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [COORD_W-1:0]  ctrl_x;
        logic signed [COORD_W-1:0]  ctrl_y;
        logic signed [COORD_W-1:0]  ctrl2_x;
        logic signed [COORD_W-1:0]  ctrl2_y;
        logic                       glyph_end;
    } vertex_t;

    typedef struct packed {
        rec_kind_t                  record_kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  stop_x;
        logic signed [COORD_W-1:0]  stop_y;
        logic signed [COORD_W-1:0]  quad_ctrl_x;
        logic signed [COORD_W-1:0]  quad_ctrl_y;
        logic [COUNT_W-1:0]         contour_count;
        logic                       overflow;
        logic                       run_last;
    } record_t;

    // Fixed-width part of the converter state
    typedef struct packed {
        logic signed [COORD_W-1:0]  prev_x;
        logic signed [COORD_W-1:0]  prev_y;
        logic [COUNT_W-1:0]         contour_segments;
        logic                       glyph_open;
    } pos_state_t;

endpackage

[sv/gosc_core.sv]
module gosc_core
    import gosc_pkg::*;
#(
    parameter int unsigned SEGMENT_CAPACITY = SEG_CAPACITY_DEFAULT,
    localparam int unsigned IDX_W = $clog2(SEGMENT_CAPACITY + 1)
) (
    input  vertex_t            vtx,
    input  pos_state_t         st,
    input  logic [IDX_W-1:0]   write_index,
    input  logic [IDX_W-1:0]   contour_head,
    output pos_state_t         st_next,
    output logic [IDX_W-1:0]   write_index_next,
    output logic [IDX_W-1:0]   contour_head_next,
    output record_t            rec0,
    output record_t            rec1,
    output logic               push0,
    output logic               push1
);

    localparam logic [IDX_W-1:0] CAP = IDX_W'(SEGMENT_CAPACITY);

    // Sum of two coordinates halved toward zero
    function automatic logic signed [COORD_W-1:0] half_sum(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        logic signed [COORD_W:0] t;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        t = s + {{COORD_W{1'b0}}, s[COORD_W]};
        half_sum = t[COORD_W:1];
    endfunction

    logic                       first_vtx;
    logic                       move_vtx;
    logic                       draw_vtx;
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    record_t                    seg_rec;
    record_t                    patch_old;
    record_t                    patch_new;

    assign first_vtx = !st.glyph_open;
    assign move_vtx  = st.glyph_open && (vtx.kind == KIND_MOVE);
    assign draw_vtx  = st.glyph_open && (vtx.kind != KIND_MOVE);

    // Pick the quadratic control point for the vertex kind
    always_comb begin
        case (vtx.kind)
            KIND_LINE: begin
                qx = half_sum(st.prev_x, vtx.end_x);
                qy = half_sum(st.prev_y, vtx.end_y);
            end
            KIND_QUAD: begin
                qx = vtx.ctrl_x;
                qy = vtx.ctrl_y;
            end
            KIND_CUBIC: begin
                qx = half_sum(vtx.ctrl_x, vtx.ctrl2_x);
                qy = half_sum(vtx.ctrl_y, vtx.ctrl2_y);
            end
            default: begin
                qx = '0;
                qy = '0;
            end
        endcase
    end

    // Advance head, count, write index, previous point and glyph flag
    always_comb begin
        st_next.prev_x     = vtx.end_x;
        st_next.prev_y     = vtx.end_y;
        st_next.glyph_open = !vtx.glyph_end;
        write_index_next   = write_index;
        contour_head_next  = contour_head;
        st_next.contour_segments = st.contour_segments;
        if (first_vtx || move_vtx) begin
            contour_head_next        = write_index;
            st_next.contour_segments = '0;
        end else begin
            if (write_index < CAP) begin
                write_index_next = write_index + IDX_W'(1);
            end
            if (st.contour_segments < COUNT_MAX) begin
                st_next.contour_segments = st.contour_segments + COUNT_W'(1);
            end
        end
    end

    // Build the segment record and both count patches
    always_comb begin
        seg_rec.record_kind   = REC_SEGMENT;
        seg_rec.slot          = SLOT_W'(write_index);
        seg_rec.start_x       = st.prev_x;
        seg_rec.start_y       = st.prev_y;
        seg_rec.stop_x        = vtx.end_x;
        seg_rec.stop_y        = vtx.end_y;
        seg_rec.quad_ctrl_x   = qx;
        seg_rec.quad_ctrl_y   = qy;
        seg_rec.contour_count = '0;
        seg_rec.overflow      = (write_index >= CAP);
        seg_rec.run_last      = !vtx.glyph_end;

        patch_old               = '0;
        patch_old.record_kind   = REC_PATCH;
        patch_old.slot          = SLOT_W'(contour_head);
        patch_old.contour_count = st.contour_segments;
        patch_old.overflow      = (contour_head >= CAP);
        patch_old.run_last      = !vtx.glyph_end;

        patch_new               = '0;
        patch_new.record_kind   = REC_PATCH;
        patch_new.slot          = SLOT_W'(contour_head_next);
        patch_new.contour_count = st_next.contour_segments;
        patch_new.overflow      = (contour_head_next >= CAP);
        patch_new.run_last      = 1'b1;
    end

    // First result is the vertex's own; second is the closing patch
    always_comb begin
        if (first_vtx) begin
            rec0 = patch_new;
        end else if (move_vtx) begin
            rec0 = patch_old;
        end else begin
            rec0 = seg_rec;
        end
        rec1  = patch_new;
        push0 = draw_vtx || move_vtx || vtx.glyph_end;
        push1 = !first_vtx && vtx.glyph_end;
    end

endmodule

[sv/gosc_fifo.sv]
module gosc_fifo
    import gosc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push0,
    input  logic     push1,
    input  record_t  rec0,
    input  record_t  rec1,
    input  logic     pop,
    output record_t  head,
    output logic     not_empty,
    output logic     has_room
);

    record_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head      = entry_reg[rd_ptr_reg];

    // Store one or two records per transaction
    always_ff @(posedge aclk) begin
        if (push0) begin
            entry_reg[wr_ptr_reg] <= rec0;
        end
        if (push1) begin
            entry_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= rec1;
        end
    end

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                      - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue occupancy past depth");

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> push0)
        else $error("second record pushed without first");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push0 |-> $past(count_reg) <= FIFO_CNT_W'(FIFO_DEPTH) && has_room)
        else $error("record pushed into full queue");
`endif

endmodule

[sv/glyph_outline_segment_converter.sv]
// Channel  | Ports                      | Contents
// ---------+----------------------------+---------------------------------------------
// input    | s_tvalid s_tready s_tdata  | one outline vertex; tuser kind, tlast glyph end
// result   | m_tvalid m_tready m_tdata  | segment or count patch; tlast last of vertex
//
// A vertex is taken in every cycle while two entries of the four-entry result
// queue are free; it is processed in the cycle it is accepted.
// A vertex yields zero, one or two result records, each sent as its own output transfer,
// so the output port sets the sustained rate.
// Reset clears the outline state and empties the queue; no clearing pass.
// A stalled result side holds queued records and drops s_tready once room is short.
module glyph_outline_segment_converter
    import gosc_pkg::*;
#(
    parameter int unsigned SEGMENT_CAPACITY = SEG_CAPACITY_DEFAULT,
    localparam int unsigned IDX_W = $clog2(SEGMENT_CAPACITY + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // end_x, end_y, ctrl_x, ctrl_y, ctrl2_x, ctrl2_y
    input  logic [95:0]   s_tdata,
    // kind
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // slot, start_x, start_y, stop_x, stop_y, quad_ctrl_x, quad_ctrl_y,
    // contour_count, zero pad
    output logic [135:0]  m_tdata,
    // record_kind, overflow
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    pos_state_t          st_reg;
    pos_state_t          st_next;
    logic [IDX_W-1:0]    write_index_reg;
    logic [IDX_W-1:0]    write_index_next;
    logic [IDX_W-1:0]    contour_head_reg;
    logic [IDX_W-1:0]    contour_head_next;
    vertex_t             vtx;
    record_t             rec0;
    record_t             rec1;
    record_t             head;
    logic                push0;
    logic                push1;
    logic                s_accept;
    logic                has_room;

    assign s_tready = has_room;
    assign s_accept = s_tvalid && has_room;

    // Unpack the input transaction
    always_comb begin
        vtx.kind      = kind_t'(s_tuser);
        vtx.end_x     = s_tdata[15:0];
        vtx.end_y     = s_tdata[31:16];
        vtx.ctrl_x    = s_tdata[47:32];
        vtx.ctrl_y    = s_tdata[63:48];
        vtx.ctrl2_x   = s_tdata[79:64];
        vtx.ctrl2_y   = s_tdata[95:80];
        vtx.glyph_end = s_tlast;
    end

    gosc_core #(
        .SEGMENT_CAPACITY(SEGMENT_CAPACITY)
    ) u_core (
        .vtx               (vtx),
        .st                (st_reg),
        .write_index       (write_index_reg),
        .contour_head      (contour_head_reg),
        .st_next           (st_next),
        .write_index_next  (write_index_next),
        .contour_head_next (contour_head_next),
        .rec0              (rec0),
        .rec1              (rec1),
        .push0             (push0),
        .push1             (push1)
    );

    gosc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (s_accept && push0),
        .push1     (s_accept && push1),
        .rec0      (rec0),
        .rec1      (rec1),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .has_room  (has_room)
    );

    // Update outline state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg           <= '0;
            write_index_reg  <= '0;
            contour_head_reg <= '0;
        end else if (s_accept) begin
            st_reg           <= st_next;
            write_index_reg  <= write_index_next;
            contour_head_reg <= contour_head_next;
        end
    end

    // Pack the result transaction
    assign m_tdata = {4'd0, head.contour_count, head.quad_ctrl_y, head.quad_ctrl_x,
                      head.stop_y, head.stop_x, head.start_y, head.start_x, head.slot};
    assign m_tuser = {head.overflow, head.record_kind};
    assign m_tlast = head.run_last;

`ifndef NO_ASSERTIONS
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        write_index_reg <= IDX_W'(SEGMENT_CAPACITY) && contour_head_reg <= write_index_reg)
        else $error("write index or contour head out of range");

    a_glyph_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> !st_reg.glyph_open)
        else $error("glyph still open after its last vertex");

    a_move_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == KIND_MOVE |=>
            st_reg.contour_segments == '0 && contour_head_reg == $past(write_index_reg))
        else $error("move did not restart the contour");

    a_segment_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == REC_SEGMENT |-> m_tdata[131:117] == '0)
        else $error("segment record carries a contour count");
`endif

endmodule
